/* hdl/quadratic_probe_hash_table_unit_assert.svh */
// Assertion macros for the quadratic probe hash table unit.
`ifndef QUADRATIC_PROBE_HASH_TABLE_UNIT_ASSERT_SVH
`define QUADRATIC_PROBE_HASH_TABLE_UNIT_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication
`define QPH_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("qph assertion failed");
// next-cycle implication
`define QPH_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("qph assertion failed");
`else
`define QPH_ASSERT_NOW(label, clk, rst, ante, cons)
`define QPH_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* hdl/qph_pkg.sv */
// Types, codes and key helpers shared by the hash table unit.
package qph_pkg;

   localparam int KEY_W      = 64;
   localparam int IP_W       = 32;
   localparam int SUM_W      = 11;
   localparam int SLOT_OUT_W = 7;

   // probe step coefficients: slot(i) = home + C1*i + C2*i*i
   localparam int C1 = 1;
   localparam int C2 = 3;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;
   localparam logic [1:0] ST_EMPTY_KEY = 2'd3;

   localparam logic [1:0] ACT_INSERT = 2'd0;
   localparam logic [1:0] ACT_LOOKUP = 2'd1;
   localparam logic [1:0] ACT_UPDATE = 2'd2;
   localparam logic [1:0] ACT_REMOVE = 2'd3;

   typedef struct packed {
      logic             used;
      logic             deleted;
      logic [KEY_W-1:0] key;
   } qph_meta_type;

   typedef struct packed {
      logic rd_en;
      logic meta_we;
      logic ip_we;
   } qph_ctl_type;

   // keep the top nbytes bytes, up to the first zero byte
   function automatic logic [KEY_W-1:0] shape_key(input logic [KEY_W-1:0] raw,
                                                  input int nbytes);
      logic [KEY_W-1:0] res;
      logic             stop;
      logic [7:0]       bt;
      res  = '0;
      stop = 1'b0;
      for (int b = 0; b < 8; b++) begin
         bt = raw[KEY_W-8-8*b +: 8];
         if (b >= nbytes || bt == 8'd0) begin
            stop = 1'b1;
         end
         if (!stop) begin
            res[KEY_W-8-8*b +: 8] = bt;
         end
      end
      return res;
   endfunction

   function automatic logic [SUM_W-1:0] key_byte_sum(input logic [KEY_W-1:0] key);
      logic [SUM_W-1:0] sum;
      sum = '0;
      for (int b = 0; b < 8; b++) begin
         sum = sum + SUM_W'(key[8*b +: 8]);
      end
      return sum;
   endfunction

endpackage

/* hdl/quadratic_probe_hash_table_unit.sv */
// Top level: request sequencer walking the quadratic probe chain through the slot memories.
// Flow: S_HASH waits for the home slot, then each probe is a read (S_READ) then a check
//   (S_CHECK) of the slot memory, up to MAX_PROBES probes; an empty key goes straight to
//   S_FIN. One request at a time: a new one is taken only back in S_IDLE.
// Reset: synchronous, active high; afterwards a clearing pass over all TABLE_ENTRIES slots
//   empties the key store, with req_ready low until it ends.
module quadratic_probe_hash_table_unit import qph_pkg::*; #(
   parameter int TABLE_ENTRIES = 128,
   parameter int MAX_PROBES    = 128,
   parameter int KEY_BYTES     = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_action,
   input  logic [KEY_W-1:0]      req_key,
   input  logic [IP_W-1:0]       req_ip_address,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [1:0]            rsp_status,
   output logic [IP_W-1:0]       rsp_found_address,
   output logic [SLOT_OUT_W-1:0] rsp_slot_index
);
   `include "quadratic_probe_hash_table_unit_assert.svh"

   localparam int SW = $clog2(TABLE_ENTRIES);
   localparam int CW = $clog2(MAX_PROBES + 1);
   // slot(i+1) - slot(i) = C1 + C2*(2i+1): first step and its increment, mod size
   localparam logic [SW-1:0] DELTA0 = SW'((C1 + C2) % TABLE_ENTRIES);
   localparam logic [SW-1:0] DSTEP  = SW'((2 * C2) % TABLE_ENTRIES);

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_HASH  = 5'b00010,
      S_READ  = 5'b00100,
      S_CHECK = 5'b01000,
      S_FIN   = 5'b10000
   } state_type;

   state_type        state_ff, state_in;
   logic [1:0]       act_ff, act_in;
   logic [KEY_W-1:0] key_ff, key_in, key_shaped;
   logic [IP_W-1:0]  ip_ff, ip_in;
   logic [SW-1:0]    slot_ff, slot_in, delta_ff, delta_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [1:0]       res_status_ff, res_status_in;
   logic [IP_W-1:0]  res_found_ff, res_found_in;
   logic [SW-1:0]    res_slot_ff, res_slot_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [1:0]       rsp_status_ff, rsp_status_in;
   logic [IP_W-1:0]  rsp_found_ff, rsp_found_in;
   logic [SLOT_OUT_W-1:0] rsp_slot_ff, rsp_slot_in;

   logic             req_xfer, home_start, home_valid, clr_busy;
   logic [SW-1:0]    home;
   logic [SW:0]      slot_sum, delta_sum;
   logic [SW-1:0]    slot_next, delta_next;
   logic             slot_free, key_hit, last_probe, out_load;
   qph_ctl_type      ctl;
   qph_meta_type     wr_meta, rd_meta;
   logic [IP_W-1:0]  rd_ip;

   assign key_shaped = shape_key(req_key, KEY_BYTES);
   assign req_ready  = (state_ff == S_IDLE) && !clr_busy;
   assign req_xfer   = req_valid && req_ready;
   assign home_start = req_xfer && (key_shaped != '0);

   qph_home #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_home (
      .clock      (clock),
      .reset      (reset),
      .start      (home_start),
      .sum        (key_byte_sum(key_shaped)),
      .home_valid (home_valid),
      .home       (home)
   );

   // next probe slot and step, each kept below the table size
   assign slot_sum   = {1'b0, slot_ff} + {1'b0, delta_ff};
   assign slot_next  = (slot_sum >= (SW+1)'(TABLE_ENTRIES)) ?
                       SW'(slot_sum - (SW+1)'(TABLE_ENTRIES)) : slot_sum[SW-1:0];
   assign delta_sum  = {1'b0, delta_ff} + {1'b0, DSTEP};
   assign delta_next = (delta_sum >= (SW+1)'(TABLE_ENTRIES)) ?
                       SW'(delta_sum - (SW+1)'(TABLE_ENTRIES)) : delta_sum[SW-1:0];

   // evaluation of the slot just read
   assign slot_free  = !rd_meta.used || rd_meta.deleted;
   assign key_hit    = rd_meta.used && !rd_meta.deleted && (rd_meta.key == key_ff);
   assign last_probe = (cnt_ff == CW'(MAX_PROBES - 1));
   assign out_load   = (state_ff == S_FIN) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in      = state_ff;
      act_in        = act_ff;
      key_in        = key_ff;
      ip_in         = ip_ff;
      slot_in       = slot_ff;
      delta_in      = delta_ff;
      cnt_in        = cnt_ff;
      res_status_in = res_status_ff;
      res_found_in  = res_found_ff;
      res_slot_in   = res_slot_ff;
      ctl           = '0;
      wr_meta       = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               act_in        = req_action;
               key_in        = key_shaped;
               ip_in         = req_ip_address;
               res_status_in = ST_EMPTY_KEY;
               res_found_in  = '0;
               res_slot_in   = '0;
               state_in      = (key_shaped == '0) ? S_FIN : S_HASH;
            end
         end
         S_HASH: begin
            if (home_valid) begin
               slot_in  = home;
               delta_in = DELTA0;
               cnt_in   = '0;
               state_in = S_READ;
            end
         end
         S_READ: begin
            ctl.rd_en = 1'b1;
            state_in  = S_CHECK;
         end
         S_CHECK: begin
            state_in = S_FIN;
            if (act_ff == ACT_INSERT && slot_free) begin
               ctl.meta_we   = 1'b1;
               ctl.ip_we     = 1'b1;
               wr_meta       = '{used: 1'b1, deleted: 1'b0, key: key_ff};
               res_status_in = ST_OK;
               res_slot_in   = slot_ff;
            end else if (act_ff != ACT_INSERT && !rd_meta.used) begin
               res_status_in = ST_NOT_FOUND;
            end else if (act_ff != ACT_INSERT && key_hit) begin
               res_status_in = ST_OK;
               res_slot_in   = slot_ff;
               case (act_ff)
                  ACT_LOOKUP: res_found_in = rd_ip;
                  ACT_UPDATE: ctl.ip_we = 1'b1;
                  default: begin
                     // remove: keep the key, set the deleted mark
                     ctl.meta_we = 1'b1;
                     wr_meta     = '{used: 1'b1, deleted: 1'b1, key: rd_meta.key};
                  end
               endcase
            end else if (last_probe) begin
               res_status_in = (act_ff == ACT_INSERT) ? ST_FULL : ST_NOT_FOUND;
            end else begin
               slot_in  = slot_next;
               delta_in = delta_next;
               cnt_in   = cnt_ff + 1'b1;
               state_in = S_READ;
            end
         end
         S_FIN: begin
            if (out_load) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   qph_store #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_store (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl),
      .addr     (slot_ff),
      .wr_meta  (wr_meta),
      .wr_ip    (ip_ff),
      .rd_meta  (rd_meta),
      .rd_ip    (rd_ip),
      .clr_busy (clr_busy)
   );

   // output register: holds a finished result until its transfer
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_slot_in   = rsp_slot_ff;
      if (out_load) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = res_status_ff;
         rsp_found_in  = res_found_ff;
         rsp_slot_in   = SLOT_OUT_W'(res_slot_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff        <= act_in;
      key_ff        <= key_in;
      ip_ff         <= ip_in;
      slot_ff       <= slot_in;
      delta_ff      <= delta_in;
      cnt_ff        <= cnt_in;
      res_status_ff <= res_status_in;
      res_found_ff  <= res_found_in;
      res_slot_ff   <= res_slot_in;
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_slot_ff   <= rsp_slot_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_found_address = rsp_found_ff;
   assign rsp_slot_index    = rsp_slot_ff;

   // no request transfer while the key store is being cleared
   `QPH_ASSERT_NOW(a_no_req_in_clear, clock, reset, clr_busy, !req_ready)
   // stores are only written while checking a probed slot
   `QPH_ASSERT_NOW(a_wr_in_check, clock, reset, ctl.meta_we || ctl.ip_we, state_ff == S_CHECK)
   // probe count stays within the walk bound
   `QPH_ASSERT_NOW(a_probe_bound, clock, reset, state_ff == S_CHECK, cnt_ff < CW'(MAX_PROBES))
   // failed requests report neither slot nor address
   `QPH_ASSERT_NOW(a_fail_zero, clock, reset, rsp_valid_ff && rsp_status_ff != ST_OK,
                   rsp_slot_ff == '0 && rsp_found_ff == '0)
endmodule

/* hdl/qph_home.sv */
// Home slot: byte sum modulo table size by reciprocal multiply, two stages.
module qph_home import qph_pkg::*; #(
   parameter int TABLE_ENTRIES = 128
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [SUM_W-1:0]                 sum,
   output logic                             home_valid,
   output logic [$clog2(TABLE_ENTRIES)-1:0] home
);
   localparam int SW    = $clog2(TABLE_ENTRIES);
   localparam int SH    = 22;
   localparam int RCP_W = SH;
   localparam int NW    = $clog2(TABLE_ENTRIES + 1);
   localparam int MW    = SUM_W + NW;
   localparam logic [RCP_W-1:0] RCP = RCP_W'((64'd1 << SH) / TABLE_ENTRIES);

   logic                   v1_ff, v1_in, v2_ff, v2_in;
   logic [SUM_W-1:0]       sum1_ff, q_ff, q_in;
   logic [SUM_W+RCP_W-1:0] prod;
   logic [MW-1:0]          qn, rem, rem_fix;
   logic [SW-1:0]          home_ff, home_in;

   // quotient estimate is exact or one short
   assign prod = (SUM_W+RCP_W)'(sum) * (SUM_W+RCP_W)'(RCP);
   assign q_in = prod[SH +: SUM_W];

   assign qn      = MW'(q_ff) * MW'(TABLE_ENTRIES);
   assign rem     = MW'(sum1_ff) - qn;
   assign rem_fix = (rem >= MW'(TABLE_ENTRIES)) ? rem - MW'(TABLE_ENTRIES) : rem;
   assign home_in = rem_fix[SW-1:0];

   assign v1_in = start;
   assign v2_in = v1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
      end
   end

   always_ff @(posedge clock) begin
      sum1_ff <= sum;
      q_ff    <= q_in;
      home_ff <= home_in;
   end

   assign home_valid = v2_ff;
   assign home       = home_ff;
endmodule

/* hdl/qph_store.sv */
// Slot memories: key/flags store with clearing pass, and address store.
module qph_store import qph_pkg::*; #(
   parameter int TABLE_ENTRIES = 128
) (
   input  logic                             clock,
   input  logic                             reset,
   input  qph_ctl_type                      ctl,
   input  logic [$clog2(TABLE_ENTRIES)-1:0] addr,
   input  qph_meta_type                     wr_meta,
   input  logic [IP_W-1:0]                  wr_ip,
   output qph_meta_type                     rd_meta,
   output logic [IP_W-1:0]                  rd_ip,
   output logic                             clr_busy
);
   localparam int SW = $clog2(TABLE_ENTRIES);

   qph_meta_type    meta_mem [TABLE_ENTRIES];
   logic [IP_W-1:0] ip_mem   [TABLE_ENTRIES];

   qph_meta_type    rd_meta_ff;
   logic [IP_W-1:0] rd_ip_ff;
   logic [SW-1:0]   clr_idx_ff, clr_idx_in;
   logic            clr_busy_ff, clr_busy_in;

   always_comb begin
      clr_idx_in  = clr_idx_ff;
      clr_busy_in = clr_busy_ff;
      if (clr_busy_ff) begin
         clr_idx_in = clr_idx_ff + 1'b1;
         if (clr_idx_ff == SW'(TABLE_ENTRIES - 1)) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_idx_ff  <= '0;
         clr_busy_ff <= 1'b1;
      end else begin
         clr_idx_ff  <= clr_idx_in;
         clr_busy_ff <= clr_busy_in;
      end
   end

   // key/flags store: clearing pass owns the write port until done
   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         meta_mem[clr_idx_ff] <= '0;
      end else if (ctl.meta_we) begin
         meta_mem[addr] <= wr_meta;
      end
      if (ctl.rd_en) begin
         rd_meta_ff <= meta_mem[addr];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.ip_we) begin
         ip_mem[addr] <= wr_ip;
      end
      if (ctl.rd_en) begin
         rd_ip_ff <= ip_mem[addr];
      end
   end

   assign rd_meta  = rd_meta_ff;
   assign rd_ip    = rd_ip_ff;
   assign clr_busy = clr_busy_ff;
endmodule

/* tb/quadratic_probe_hash_table_unit_test.sv */
// Self-checking testbench for the quadratic probe hash table unit.
`timescale 1ns / 100ps

module quadratic_probe_hash_table_unit_test;
   import qph_pkg::*;

   localparam int TABLE_ENTRIES = 128;
   localparam int MAX_PROBES    = 128;
   localparam int KEY_BYTES     = 8;

   // One search may walk every probe; the drain wait covers a full walk plus margin.
   localparam int DRAIN_CYCLES = 3 + 2 * MAX_PROBES + 40;
   // Slowest correct run: ~1050 transfers, each a full walk plus long stalls
   // on both sides, plus the clearing pass after reset; then taken over again.
   localparam int unsigned CYCLE_LIMIT = 2_000_000;

   localparam int NAME_POOL   = 40;
   localparam int CHAIN_HOME  = 45;

   // One response as the unit should return it.
   typedef struct packed {
      logic [1:0]            status;
      logic [IP_W-1:0]       found_address;
      logic [SLOT_OUT_W-1:0] slot_index;
   } dns_reply_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [1:0]            req_action;
   logic [KEY_W-1:0]      req_key;
   logic [IP_W-1:0]       req_ip_address;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [1:0]            rsp_status;
   logic [IP_W-1:0]       rsp_found_address;
   logic [SLOT_OUT_W-1:0] rsp_slot_index;

   // Shadow copy of the slot stores, updated as each request transfer is taken.
   logic [KEY_W-1:0] mirror_key     [TABLE_ENTRIES];
   logic             mirror_used    [TABLE_ENTRIES];
   logic             mirror_deleted [TABLE_ENTRIES];
   logic [IP_W-1:0]  mirror_addr    [TABLE_ENTRIES];

   dns_reply_type    expected_replies [$];
   logic [1:0]       last_status;

   // Names reused by the random traffic so that hits are common.
   logic [KEY_W-1:0] name_pool [NAME_POOL];
   int unsigned      name_len  [NAME_POOL];

   int unsigned sender_idle_pct    = 0;
   int unsigned receiver_stall_pct = 0;
   int unsigned mismatch_count     = 0;
   int unsigned cycle_count        = 0;

   quadratic_probe_hash_table_unit #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .MAX_PROBES    (MAX_PROBES),
      .KEY_BYTES     (KEY_BYTES)
   ) u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_action        (req_action),
      .req_key           (req_key),
      .req_ip_address    (req_ip_address),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_found_address (rsp_found_address),
      .rsp_slot_index    (rsp_slot_index)
   );

   always #6 clock = ~clock;

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------

   // Only the top KEY_BYTES bytes count, and the name stops at its first NUL.
   function automatic logic [KEY_W-1:0] trim_key(input logic [KEY_W-1:0] raw);
      logic [KEY_W-1:0] name;
      logic [7:0]       ch;
      name = '0;
      for (int b = 0; b < KEY_BYTES; b++) begin
         ch = raw[KEY_W-1-8*b -: 8];
         if (ch == 8'd0) break;
         name[KEY_W-1-8*b -: 8] = ch;
      end
      return name;
   endfunction

   // Home bucket: plain byte sum, folded onto the table.
   function automatic int unsigned home_bucket(input logic [KEY_W-1:0] name);
      int unsigned sum;
      sum = 0;
      for (int b = 0; b < 8; b++) sum += name[8*b +: 8];
      return sum % TABLE_ENTRIES;
   endfunction

   function automatic int unsigned probe_bucket(input int unsigned home, input int unsigned i);
      return (home + C1 * i + C2 * i * i) % TABLE_ENTRIES;
   endfunction

   // Apply one request to the shadow table and queue the response it earns.
   task automatic resolve_request(input logic [1:0] act, input logic [KEY_W-1:0] raw,
                                  input logic [IP_W-1:0] ip);
      logic [KEY_W-1:0] name;
      dns_reply_type    r;
      int unsigned      home;
      int unsigned      s;
      name            = trim_key(raw);
      r.status        = ST_NOT_FOUND;
      r.found_address = '0;
      r.slot_index    = '0;
      if (name == '0) begin
         r.status = ST_EMPTY_KEY;
      end else if (act == ACT_INSERT) begin
         // insert takes the first free or tombstoned bucket, no duplicate check
         home     = home_bucket(name);
         r.status = ST_FULL;
         for (int i = 0; i < MAX_PROBES; i++) begin
            s = probe_bucket(home, i);
            if (!mirror_used[s] || mirror_deleted[s]) begin
               mirror_key[s]     = name;
               mirror_addr[s]    = ip;
               mirror_used[s]    = 1'b1;
               mirror_deleted[s] = 1'b0;
               r.status          = ST_OK;
               r.slot_index      = SLOT_OUT_W'(s);
               break;
            end
         end
      end else begin
         // searches stop at a never-used bucket and step over tombstones
         home = home_bucket(name);
         for (int i = 0; i < MAX_PROBES; i++) begin
            s = probe_bucket(home, i);
            if (!mirror_used[s]) break;
            if (!mirror_deleted[s] && mirror_key[s] == name) begin
               r.status     = ST_OK;
               r.slot_index = SLOT_OUT_W'(s);
               case (act)
                  ACT_LOOKUP: r.found_address = mirror_addr[s];
                  ACT_UPDATE: mirror_addr[s] = ip;
                  default:    mirror_deleted[s] = 1'b1;
               endcase
               break;
            end
         end
      end
      expected_replies.push_back(r);
      last_status = r.status;
   endtask

   // ---------------------------------------------------------------------
   // Request side: drive at the falling edge, take the transfer at the rising
   // edge. Valid is left high after a transfer; the next call may first drop it
   // for idle cycles, then always moves on to fresh payload.
   // ---------------------------------------------------------------------
   task automatic transfer_request(input logic [1:0] act, input logic [KEY_W-1:0] key,
                                   input logic [IP_W-1:0] ip);
      @(negedge clock);
      while ($urandom_range(99, 0) < sender_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_action     = act;
      req_key        = key;
      req_ip_address = ip;
      req_valid      = 1'b1;
      do @(posedge clock); while (!req_ready);
      resolve_request(act, key, ip);
   endtask

   // Response side back-pressure, redrawn every cycle.
   always @(negedge clock) begin
      rsp_ready = ($urandom_range(99, 0) >= receiver_stall_pct);
   end

   // Compare every response transfer with the oldest prediction.
   always @(posedge clock) begin : reply_check
      dns_reply_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_replies.size() == 0) begin
            $error("unexpected response: status %0d, address %h, slot %0d",
                   rsp_status, rsp_found_address, rsp_slot_index);
            mismatch_count++;
         end else begin
            want = expected_replies.pop_front();
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               mismatch_count++;
            end
            if (rsp_found_address !== want.found_address) begin
               $error("found_address: expected %h, got %h",
                      want.found_address, rsp_found_address);
               mismatch_count++;
            end
            if (rsp_slot_index !== want.slot_index) begin
               $error("slot_index: expected %0d, got %0d", want.slot_index, rsp_slot_index);
               mismatch_count++;
            end
         end
      end
   end

   // Hang guard.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Every action, field extremes, name trimming, duplicates and tombstones.
   task automatic test_directed_actions();
      localparam logic [KEY_W-1:0] HOST      = 64'h686F_7374_0000_0000;  // "host"
      localparam logic [KEY_W-1:0] HOST_TAIL = 64'h686F_7374_006A_756E;  // "host", NUL, junk
      localparam logic [KEY_W-1:0] ANAGRAM   = 64'h7473_6F68_0000_0000;  // same byte sum
      localparam logic [KEY_W-1:0] ONE_CHAR  = 64'h7A00_0000_0000_0000;
      transfer_request(ACT_LOOKUP, 64'h6100_0000_0000_0000, '0);  // empty table
      transfer_request(ACT_INSERT, '0, 32'hFFFF_FFFF);             // empty key
      transfer_request(ACT_LOOKUP, 64'h00FF_FFFF_FFFF_FFFF, '0);   // leading NUL
      transfer_request(ACT_INSERT, HOST, 32'hFFFF_FFFF);
      transfer_request(ACT_LOOKUP, HOST, '0);
      transfer_request(ACT_INSERT, {KEY_W{1'b1}}, '0);
      transfer_request(ACT_LOOKUP, {KEY_W{1'b1}}, 32'hFFFF_FFFF);
      transfer_request(ACT_UPDATE, HOST, 32'h0A00_0001);
      transfer_request(ACT_LOOKUP, HOST_TAIL, '0);                 // junk past NUL ignored
      transfer_request(ACT_INSERT, HOST, 32'hC0A8_0001);           // second copy
      transfer_request(ACT_REMOVE, HOST, '0);                      // first copy goes
      transfer_request(ACT_LOOKUP, HOST, '0);                      // steps over tombstone
      transfer_request(ACT_REMOVE, HOST_TAIL, '0);
      transfer_request(ACT_LOOKUP, HOST, '0);                      // both gone
      transfer_request(ACT_UPDATE, HOST, 32'h1234_5678);
      transfer_request(ACT_REMOVE, HOST, '0);
      transfer_request(ACT_INSERT, ANAGRAM, 32'h5555_AAAA);        // reuses tombstone
      transfer_request(ACT_INSERT, ONE_CHAR, $urandom());
      transfer_request(ACT_UPDATE, ONE_CHAR, 32'hAAAA_5555);
      transfer_request(ACT_LOOKUP, ONE_CHAR, '0);
      transfer_request(ACT_REMOVE, ONE_CHAR, '0);
      transfer_request(ACT_UPDATE, '0, 32'hFFFF_FFFF);             // empty key
      transfer_request(ACT_REMOVE, 64'h0011_2233_4455_6677, '0);   // empty key
   endtask

   // Three-byte name whose byte sum lands on the given home bucket.
   function automatic logic [KEY_W-1:0] colliding_key(input int unsigned home);
      int unsigned a;
      int unsigned b;
      int unsigned c;
      a = $urandom_range(255, 1);
      b = $urandom_range(255, 1);
      c = (home + 512 - a - b) % TABLE_ENTRIES;
      if (c == 0) c = TABLE_ENTRIES;
      return {a[7:0], b[7:0], c[7:0], 40'h0};
   endfunction

   // Fill one probe chain until insert reports a full table; searches then
   // run out of probes without reaching a free bucket. Drain it afterwards.
   task automatic test_chain_saturation();
      logic [KEY_W-1:0] chain [$];
      logic [KEY_W-1:0] name;
      int unsigned      guard;
      guard       = 0;
      last_status = ST_OK;
      while (last_status != ST_FULL && guard < 2 * MAX_PROBES) begin
         name = colliding_key(CHAIN_HOME);
         transfer_request(ACT_INSERT, name, $urandom());
         if (last_status == ST_OK) chain.push_back(name);
         guard++;
      end
      transfer_request(ACT_INSERT, colliding_key(CHAIN_HOME), $urandom());
      transfer_request(ACT_LOOKUP, colliding_key(CHAIN_HOME), '0);
      transfer_request(ACT_UPDATE, colliding_key(CHAIN_HOME), $urandom());
      transfer_request(ACT_REMOVE, colliding_key(CHAIN_HOME), '0);
      // deepest entry of the chain
      transfer_request(ACT_UPDATE, chain[$], $urandom());
      transfer_request(ACT_LOOKUP, chain[$], '0);
      for (int n = chain.size() - 1; n >= 0; n--) begin
         transfer_request(ACT_REMOVE, chain[n], '0);
      end
      // chain is all tombstones now: insert lands on the home bucket again
      name = colliding_key(CHAIN_HOME);
      transfer_request(ACT_INSERT, name, $urandom());
      transfer_request(ACT_LOOKUP, name, '0);
   endtask

   // Mostly names from the pool (some with junk past the NUL), plus raw
   // noise keys and empty keys.
   task automatic test_random_traffic(input int unsigned items, input int unsigned send_pct,
                                      input int unsigned recv_pct);
      logic [1:0]       act;
      logic [KEY_W-1:0] key;
      int unsigned      pick;
      int unsigned      idx;
      sender_idle_pct    = send_pct;
      receiver_stall_pct = recv_pct;
      repeat (items) begin
         pick = $urandom_range(99, 0);
         if (pick < 28)      act = ACT_INSERT;
         else if (pick < 58) act = ACT_LOOKUP;
         else if (pick < 75) act = ACT_UPDATE;
         else                act = ACT_REMOVE;
         pick = $urandom_range(99, 0);
         if (pick < 85) begin
            idx = $urandom_range(NAME_POOL - 1, 0);
            key = name_pool[idx];
            if (name_len[idx] < 7 && $urandom_range(3, 0) == 0) begin
               for (int b = name_len[idx] + 1; b < 8; b++) begin
                  key[KEY_W-1-8*b -: 8] = 8'($urandom_range(255, 0));
               end
            end
         end else if (pick < 95) begin
            key = {$urandom(), $urandom()};
         end else begin
            key = {8'h00, 24'($urandom()), $urandom()};
         end
         transfer_request(act, key, $urandom());
      end
   endtask

   // ---------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------
   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_action     = ACT_INSERT;
      req_key        = '0;
      req_ip_address = '0;
      rsp_ready      = 1'b0;
      for (int s = 0; s < TABLE_ENTRIES; s++) begin
         mirror_key[s]     = '0;
         mirror_used[s]    = 1'b0;
         mirror_deleted[s] = 1'b0;
         mirror_addr[s]    = '0;
      end
      // pool: 1 to 8 chars, mostly lower case, some arbitrary non-zero bytes
      for (int p = 0; p < NAME_POOL; p++) begin
         name_len[p]  = $urandom_range(8, 1);
         name_pool[p] = '0;
         for (int b = 0; b < name_len[p]; b++) begin
            name_pool[p][KEY_W-1-8*b -: 8] = ($urandom_range(4, 0) == 0) ?
                                             8'($urandom_range(255, 1)) :
                                             8'($urandom_range(8'h7A, 8'h61));
         end
      end

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      // the clearing pass holds req_ready low; the first transfer waits it out

      test_directed_actions();
      test_chain_saturation();
      test_random_traffic(220, 0, 0);
      test_random_traffic(220, 85, 0);
      test_random_traffic(220, 0, 85);
      test_random_traffic(220, 20, 20);

      @(negedge clock);
      req_valid = 1'b0;
      while (expected_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
